@@ design/lfsm_pkg.sv @@
`timescale 1ns / 1ps
package lfsm_pkg;

   localparam int DIV_DW = 44;
   localparam int DIV_VW = 23;
   localparam int DIV_CW = 6;

   localparam int CORD_W  = 34;
   localparam int CORD_ZW = 25;
   localparam int CORD_N  = 16;
   localparam int CORD_IW = 4;

   localparam logic [DIV_VW-1:0]          TURN_UNITS   = 23'd5898240;
   localparam logic signed [CORD_ZW-1:0]  HALF_UNITS   = 25'sd2949120;
   localparam logic signed [CORD_ZW-1:0]  TURN_UNITS_S = 25'sd5898240;
   localparam logic signed [CORD_ZW-1:0]  QTR_UNITS    = 25'sd1474560;
   localparam logic signed [CORD_W-1:0]   CORD_K       = 34'sd652032874;
   localparam logic signed [CORD_W-1:0]   RATIO_ONE    = 34'sd65536;
   localparam logic signed [41:0]         FULL_TURN    = 42'sd1509949440;

   localparam logic [1:0] REG_MAX_RANGE = 2'd0;
   localparam logic [1:0] REG_X_LIMIT   = 2'd1;
   localparam logic [1:0] REG_Y_LIMIT   = 2'd2;

   typedef struct packed {
      logic              start;
      logic [DIV_DW-1:0] dividend;
      logic [DIV_VW-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                      start;
      logic                      vector_mode;
      logic signed [CORD_W-1:0]  x;
      logic signed [CORD_W-1:0]  y;
      logic signed [CORD_ZW-1:0] z;
   } cordic_req_type;

   typedef struct packed {
      logic                      done;
      logic signed [CORD_W-1:0]  x;
      logic signed [CORD_W-1:0]  y;
      logic signed [CORD_ZW-1:0] z;
   } cordic_rsp_type;

   function automatic logic signed [CORD_ZW-1:0] atan_entry(input logic [CORD_IW-1:0] i);
      logic signed [CORD_ZW-1:0] v;
      unique case (i)
         4'd0:  v = 25'sd737280;
         4'd1:  v = 25'sd435242;
         4'd2:  v = 25'sd229970;
         4'd3:  v = 25'sd116736;
         4'd4:  v = 25'sd58595;
         4'd5:  v = 25'sd29326;
         4'd6:  v = 25'sd14667;
         4'd7:  v = 25'sd7334;
         4'd8:  v = 25'sd3667;
         4'd9:  v = 25'sd1833;
         4'd10: v = 25'sd917;
         4'd11: v = 25'sd458;
         4'd12: v = 25'sd229;
         4'd13: v = 25'sd115;
         4'd14: v = 25'sd57;
         4'd15: v = 25'sd29;
         default: v = 25'sd0;
      endcase
      return v;
   endfunction

endpackage

@@ design/lfsm_div.sv @@
`timescale 1ns / 1ps
module lfsm_div (
   input  logic                         clock,
   input  logic                         reset,
   input  lfsm_pkg::div_req_type        req,
   output logic                         done,
   output logic [lfsm_pkg::DIV_DW-1:0]  quotient
);
   import lfsm_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIV_CW-1:0] cnt_ff, cnt_in;
   logic [DIV_DW-1:0] dq_ff, dq_in;
   logic [DIV_VW-1:0] rem_ff, rem_in;
   logic [DIV_VW-1:0] dvs_ff, dvs_in;
   logic [DIV_VW:0]   trial;

   always_comb begin
      trial   = {rem_ff, dq_ff[DIV_DW-1]} - {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dq_in   = req.dividend;
         rem_in  = '0;
         dvs_in  = req.divisor;
      end else if (busy_ff) begin
         dq_in  = {dq_ff[DIV_DW-2:0], ~trial[DIV_VW]};
         rem_in = trial[DIV_VW] ? {rem_ff[DIV_VW-2:0], dq_ff[DIV_DW-1]} : trial[DIV_VW-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CW'(DIV_DW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = dq_ff;

endmodule

@@ design/lfsm_cordic.sv @@
`timescale 1ns / 1ps
module lfsm_cordic (
   input  logic                     clock,
   input  logic                     reset,
   input  lfsm_pkg::cordic_req_type req,
   output lfsm_pkg::cordic_rsp_type rsp
);
   import lfsm_pkg::*;

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic                      mode_ff, mode_in;
   logic [CORD_IW-1:0]        cnt_ff, cnt_in;
   logic signed [CORD_W-1:0]  x_ff, x_in, y_ff, y_in, xs, ys;
   logic signed [CORD_ZW-1:0] z_ff, z_in, tab;
   logic                      pos;

   always_comb begin
      xs  = x_ff >>> cnt_ff;
      ys  = y_ff >>> cnt_ff;
      tab = atan_entry(cnt_ff);
      pos = mode_ff ? y_ff[CORD_W-1] : ~z_ff[CORD_ZW-1];
      busy_in = busy_ff;
      done_in = 1'b0;
      mode_in = mode_ff;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (req.start) begin
         busy_in = 1'b1;
         mode_in = req.vector_mode;
         cnt_in  = '0;
         x_in    = req.x;
         y_in    = req.y;
         z_in    = req.z;
      end else if (busy_ff) begin
         if (pos) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - tab;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + tab;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CORD_IW'(CORD_N - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      mode_ff <= mode_in;
      cnt_ff  <= cnt_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
   end

   assign rsp.done = done_ff;
   assign rsp.x    = x_ff;
   assign rsp.y    = y_ff;
   assign rsp.z    = z_ff;

endmodule

@@ design/lidar_frame_sample_mapper.sv @@
`timescale 1ns / 1ps
// channel   dir  handshake             payload
// req_      in   req_tvalid/tready     tdata[7:0] rx_byte
// rsp_      out  rsp_tvalid/tready     tdata: bin, distance, x, y, angle; tlast
// csr_      in   csr_valid/ready       csr_index, csr_data
//
// Header and angle bytes are taken while idle; the end-angle byte also starts the
// step division. The second byte of a sample runs one pass through the shared
// restoring divider (correction ratio) and two passes through the shared CORDIC
// unit; when the distance is zero, the divider and the second CORDIC pass are skipped.
// Reset is synchronous. A waiting result holds the output register while new
// bytes are taken; the next result waits in its last step until it is taken.
module lidar_frame_sample_mapper #(
   parameter int MAX_SAMPLES     = 40,
   parameter int N_BINS          = 360,
   parameter int BINS_PER_DEGREE = 1
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // bin_index, range_mm, x_mm, y_mm, angle_64ths, zero pad
   output logic        rsp_tlast,   // last_in_frame
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [14:0] csr_data
);
   import lfsm_pkg::*;

   typedef enum logic [3:0] {
      PH_HUNT, PH_SYNC2, PH_TYPE, PH_COUNT, PH_SA_LO, PH_SA_HI, PH_EA_LO, PH_EA_HI,
      PH_CK_LO, PH_CK_HI, PH_D_LO, PH_D_HI
   } phase_type;

   typedef enum logic [3:0] {
      S_IDLE, S_STEP, S_PROD, S_THETA, S_TDIV, S_RED, S_ROT, S_RAT, S_VEC,
      S_MX, S_MY, S_ANG, S_OUT
   } seq_type;

   phase_type  phase_ff, phase_in;
   seq_type    seq_ff, seq_in;
   logic [14:0] max_range_ff, max_range_in, x_limit_ff, x_limit_in, y_limit_ff, y_limit_in;
   logic [7:0]  held_ff, held_in, type_ff, type_in, count_ff, count_in, sn_ff, sn_in;
   logic [14:0] start_ff, start_in, end_ff, end_in;
   logic signed [31:0] step_ff, step_in;
   logic [13:0] d_ff, d_in;
   logic signed [40:0] prod_ff, prod_in;
   logic signed [41:0] theta_ff, theta_in, a_ff, a_in, a0;
   logic        neg_ff, neg_in, rneg_ff, rneg_in;
   logic signed [CORD_W-1:0]  sin_ff, sin_in, cos_ff, cos_in;
   logic signed [CORD_ZW-1:0] corr_ff, corr_in, tt;
   logic signed [48:0] mx_ff, mx_in, my_ff, my_in, px;
   logic        rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [65:0] rsp_data_ff, rsp_data_in;
   logic [DIV_VW-1:0] red_ff, red_in;

   div_req_type     div_req;
   logic            div_done;
   logic [DIV_DW-1:0] div_q;
   cordic_req_type  cor_req;
   cordic_rsp_type  cor_rsp;

   logic        in_xfer;
   logic signed [16:0] diff;
   logic [15:0] diff_mag;
   logic signed [33:0] t_s, t_mag;
   logic [23:0] red0, red1, red2;
   logic [DIV_VW-1:0] t_pos;
   logic [17:0] d10;
   logic signed [18:0] m;
   logic [17:0] m_mag;
   logic [45:0] bprod;
   logic [23:0] b;
   logic [25:0] a64;
   logic        ok;
   logic [8:0]  bin_o;
   logic [14:0] ang_o;
   logic [8:0]  sn_next;

   lfsm_div u_div (
      .clock(clock), .reset(reset), .req(div_req),
      .done(div_done), .quotient(div_q)
   );

   lfsm_cordic u_cordic (.clock(clock), .reset(reset), .req(cor_req), .rsp(cor_rsp));

   assign req_tready = (seq_ff == S_IDLE);
   assign in_xfer    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      phase_in = phase_ff;  seq_in = seq_ff;
      max_range_in = max_range_ff;  x_limit_in = x_limit_ff;  y_limit_in = y_limit_ff;
      held_in = held_ff;  type_in = type_ff;  count_in = count_ff;  sn_in = sn_ff;
      start_in = start_ff;  end_in = end_ff;  step_in = step_ff;  d_in = d_ff;
      prod_in = prod_ff;  theta_in = theta_ff;  a_in = a_ff;  neg_in = neg_ff;
      rneg_in = rneg_ff;  sin_in = sin_ff;  cos_in = cos_ff;  corr_in = corr_ff;
      mx_in = mx_ff;  my_in = my_ff;  red_in = red_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;  rsp_last_in = rsp_last_ff;
      div_req = '0;
      cor_req = '0;

      diff = $signed({2'b00, req_tdata, held_ff[7:1]}) - $signed({2'b00, start_ff});
      if (diff < 0) diff = diff + 17'sd23040;
      diff_mag = diff[16] ? 16'(-diff) : diff[15:0];

      t_s   = 34'(theta_ff >>> 8);
      t_mag = t_s[33] ? -t_s : t_s;
      red0  = t_mag[23:0];
      red1  = (red0 >= {TURN_UNITS, 1'b0}) ? red0 - {TURN_UNITS, 1'b0} : red0;
      red2  = (red1 >= {1'b0, TURN_UNITS}) ? red1 - {1'b0, TURN_UNITS} : red1;
      t_pos = (t_s[33] && red_ff != '0) ? TURN_UNITS - red_ff : red_ff;
      tt    = $signed({2'b00, t_pos});
      if (tt > HALF_UNITS) tt = tt - TURN_UNITS_S;

      d10   = {1'b0, d_ff, 3'b000} + {3'b000, d_ff, 1'b0};
      m     = 19'sd1553 - $signed({1'b0, d10});
      m_mag = m[18] ? 18'(-m) : m[17:0];

      a0 = theta_ff + ($signed({{17{corr_ff[CORD_ZW-1]}}, corr_ff}) <<< 8);
      if (a0 >= FULL_TURN) a0 = a0 - FULL_TURN;
      if (a0 < 0) a0 = a0 + FULL_TURN;

      bprod = 46'(a_ff[40:0]) * 46'(BINS_PER_DEGREE);
      b     = bprod[45:22];
      a64   = a_ff[41:16];
      bin_o = (!a_ff[41] && b < 24'(N_BINS)) ? b[8:0] : 9'd0;
      ang_o = a_ff[41] ? 15'd0 : ((a64 > 26'd32767) ? 15'd32767 : a64[14:0]);
      px    = -mx_ff;
      ok    = (d_ff != '0) && ({1'b0, d_ff} < max_range_ff)
              && px > 0 && px < $signed({4'b0000, x_limit_ff, 30'd0})
              && my_ff > 0 && my_ff < $signed({4'b0000, y_limit_ff, 30'd0});
      sn_next = {1'b0, sn_ff} + 9'd1;

      if (csr_valid) begin
         unique case (csr_index)
            REG_MAX_RANGE: max_range_in = csr_data;
            REG_X_LIMIT:   x_limit_in   = csr_data;
            REG_Y_LIMIT:   y_limit_in   = csr_data;
            default: ;
         endcase
      end

      unique case (seq_ff)
         S_IDLE: begin
            if (in_xfer) begin
               unique case (phase_ff)
                  PH_HUNT:  if (req_tdata == 8'hAA) phase_in = PH_SYNC2;
                  PH_SYNC2: begin
                     if (req_tdata == 8'h55) phase_in = PH_TYPE;
                     else if (req_tdata != 8'hAA) phase_in = PH_HUNT;
                  end
                  PH_TYPE: begin
                     type_in  = req_tdata;
                     phase_in = PH_COUNT;
                  end
                  PH_COUNT: begin
                     if (req_tdata == 8'd0 || req_tdata > 8'(MAX_SAMPLES)) begin
                        if (type_ff == 8'hAA && req_tdata == 8'h55) phase_in = PH_TYPE;
                        else if (req_tdata == 8'hAA) phase_in = PH_SYNC2;
                        else phase_in = PH_HUNT;
                     end else begin
                        count_in = req_tdata;
                        phase_in = PH_SA_LO;
                     end
                  end
                  PH_SA_LO, PH_EA_LO, PH_D_LO: begin
                     held_in  = req_tdata;
                     phase_in = phase_type'(phase_ff + 4'd1);
                  end
                  PH_SA_HI: begin
                     start_in = {req_tdata, held_ff[7:1]};
                     phase_in = PH_EA_LO;
                  end
                  PH_EA_HI: begin
                     end_in  = {req_tdata, held_ff[7:1]};
                     neg_in  = diff[16];
                     div_req.start    = 1'b1;
                     div_req.dividend = DIV_DW'({diff_mag, 16'd0});
                     div_req.divisor  = (count_ff > 8'd1) ? DIV_VW'(count_ff - 8'd1)
                                                          : DIV_VW'(1);
                     phase_in = PH_CK_LO;
                     seq_in   = S_STEP;
                  end
                  PH_CK_LO: phase_in = PH_CK_HI;
                  PH_CK_HI: begin
                     sn_in    = 8'd0;
                     phase_in = PH_D_LO;
                  end
                  PH_D_HI: begin
                     d_in   = {req_tdata, held_ff[7:2]};
                     seq_in = S_PROD;
                  end
                  default: phase_in = PH_HUNT;
               endcase
            end
         end
         S_STEP: begin
            if (div_done) begin
               step_in = neg_ff ? -$signed(div_q[31:0]) : $signed(div_q[31:0]);
               seq_in  = S_IDLE;
            end
         end
         S_PROD: begin
            prod_in = step_ff * $signed({1'b0, sn_ff});
            seq_in  = S_THETA;
         end
         S_THETA: begin
            theta_in = $signed({11'd0, start_ff, 16'd0}) + 42'(prod_ff);
            seq_in   = S_TDIV;
         end
         S_TDIV: begin
            red_in = red2[DIV_VW-1:0];
            seq_in = S_RED;
         end
         S_RED: begin
            rneg_in = 1'b0;
            if (tt > QTR_UNITS) begin
               tt = tt - HALF_UNITS;
               rneg_in = 1'b1;
            end else if (tt < -QTR_UNITS) begin
               tt = tt + HALF_UNITS;
               rneg_in = 1'b1;
            end
            cor_req.start = 1'b1;
            cor_req.x     = CORD_K;
            cor_req.z     = tt;
            seq_in = S_ROT;
         end
         S_ROT: begin
            if (cor_rsp.done) begin
               cos_in = rneg_ff ? -cor_rsp.x : cor_rsp.x;
               sin_in = rneg_ff ? -cor_rsp.y : cor_rsp.y;
               if (d_ff != '0) begin
                  neg_in = m[18];
                  div_req.start    = 1'b1;
                  div_req.dividend = DIV_DW'({26'(m_mag) * 26'd218, 16'd0});
                  div_req.divisor  = DIV_VW'(21'd15530 + 21'(d_ff) * 21'd100);
                  seq_in = S_RAT;
               end else begin
                  corr_in = '0;
                  seq_in  = S_MX;
               end
            end
         end
         S_RAT: begin
            if (div_done) begin
               cor_req.start       = 1'b1;
               cor_req.vector_mode = 1'b1;
               cor_req.x           = RATIO_ONE;
               cor_req.y           = neg_ff ? -$signed(div_q[CORD_W-1:0])
                                            : $signed(div_q[CORD_W-1:0]);
               seq_in = S_VEC;
            end
         end
         S_VEC: begin
            if (cor_rsp.done) begin
               corr_in = cor_rsp.z;
               seq_in  = S_MX;
            end
         end
         S_MX: begin
            mx_in  = $signed({1'b0, d_ff}) * sin_ff;
            seq_in = S_MY;
         end
         S_MY: begin
            my_in  = $signed({1'b0, d_ff}) * cos_ff;
            seq_in = S_ANG;
         end
         S_ANG: begin
            a_in   = a0;
            seq_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {ang_o, ok ? px[43:30] : 14'd0, ok ? px[43:30] : 14'd0,
                               ok ? d_ff : 14'd0, bin_o};
               rsp_data_in[50:37] = ok ? my_ff[43:30] : 14'd0;
               rsp_last_in  = (sn_next == {1'b0, count_ff});
               sn_in        = sn_next[7:0];
               phase_in     = (sn_next >= {1'b0, count_ff}) ? PH_HUNT : PH_D_LO;
               seq_in       = S_IDLE;
            end
         end
         default: seq_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         seq_ff       <= S_IDLE;
         max_range_ff <= 15'd8000;
         x_limit_ff   <= 15'd3000;
         y_limit_ff   <= 15'd3000;
         held_ff      <= '0;
         type_ff      <= '0;
         count_ff     <= '0;
         sn_ff        <= '0;
         start_ff     <= '0;
         end_ff       <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         seq_ff       <= seq_in;
         max_range_ff <= max_range_in;
         x_limit_ff   <= x_limit_in;
         y_limit_ff   <= y_limit_in;
         held_ff      <= held_in;
         type_ff      <= type_in;
         count_ff     <= count_in;
         sn_ff        <= sn_in;
         start_ff     <= start_in;
         end_ff       <= end_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      d_ff        <= d_in;
      prod_ff     <= prod_in;
      theta_ff    <= theta_in;
      red_ff      <= red_in;
      a_ff        <= a_in;
      neg_ff      <= neg_in;
      rneg_ff     <= rneg_in;
      sin_ff      <= sin_in;
      cos_ff      <= cos_in;
      corr_ff     <= corr_in;
      mx_ff       <= mx_in;
      my_ff       <= my_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_data_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_empty_point: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[22:9] == 14'd0) |->
      (rsp_tdata[36:23] == 14'd0 && rsp_tdata[50:37] == 14'd0))
      else $error("empty sample carries coordinates");
   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared without a computation");
   a_end_angle_busy: assert property (@(posedge clock) disable iff (reset)
      (seq_ff == S_STEP) |=> (seq_ff == S_STEP || seq_ff == S_IDLE))
      else $error("step division left for the sample path");
`endif

endmodule
